>>> design/lsdc_pkg.sv
`default_nettype none

package lsdc_pkg;

  // Configuration port
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 18;

  localparam logic [CFG_INDEX_W-1:0] REG_DISPLAY_WIDTH  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_DISPLAY_HEIGHT = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_X_OFFSET       = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_X_RATIO        = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_Y_RATIO        = 3'd4;

  localparam logic [8:0]  RESET_DISPLAY_WIDTH  = 9'd128;
  localparam logic [8:0]  RESET_DISPLAY_HEIGHT = 9'd128;
  localparam logic [7:0]  RESET_X_OFFSET       = 8'd0;
  localparam logic [17:0] RESET_X_RATIO        = 18'd65536;
  localparam logic [17:0] RESET_Y_RATIO        = 18'd65536;

  localparam int PALETTE_DEPTH = 16;

  typedef enum logic [2:0] {
    FUNC_BG_WRITE  = 3'd0,
    FUNC_PLOT      = 3'd1,
    FUNC_PAL_WRITE = 3'd2,
    FUNC_RENDER    = 3'd3,
    FUNC_END_FRAME = 3'd4,
    FUNC_MARK_ALL  = 3'd5
  } func_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_LOOKUP,
    ST_PLOT_WR,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic capture;
    logic clr_en;
    logic bg_wr;
    logic plot_rd;
    logic plot_wr;
    logic pal_wr;
    logic map_en;
    logic lookup_rd;
    logic out_load;
    logic dirty_clear;
    logic dirty_set_all;
  } cmd_t;

  typedef struct packed {
    func_e func;
    logic  clr_last;
    logic  bg_addr_ok;
    logic  plot_ok;
    logic  render_ok;
    logic  line_dirty;
    logic  out_free;
  } status_t;

endpackage

`default_nettype wire

>>> design/lsdc_ram.sv
`default_nettype none

module lsdc_ram #(
  parameter int Width = 8,
  parameter int Depth = 8192
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> design/lsdc_ctrl.sv
`default_nettype none

module lsdc_ctrl
  import lsdc_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_ready_o,
  input  wire status_t status_i,
  output cmd_t         cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_en = 1'b1;
        if (status_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
        if (in_valid_i) begin
          state_d = ST_DECODE;
        end
      end
      ST_DECODE: begin
        state_d = ST_IDLE;
        case (status_i.func)
          FUNC_BG_WRITE: cmd_o.bg_wr = status_i.bg_addr_ok;
          FUNC_PLOT: begin
            if (status_i.plot_ok) begin
              cmd_o.plot_rd = 1'b1;
              state_d       = ST_PLOT_WR;
            end
          end
          FUNC_PAL_WRITE: cmd_o.pal_wr = 1'b1;
          FUNC_RENDER: begin
            if (status_i.render_ok) begin
              cmd_o.map_en = 1'b1;
              state_d      = ST_LOOKUP;
            end
          end
          FUNC_END_FRAME: cmd_o.dirty_clear = 1'b1;
          FUNC_MARK_ALL:  cmd_o.dirty_set_all = 1'b1;
          default: ;
        endcase
      end
      ST_LOOKUP: begin
        // clean line: drop the render
        if (status_i.line_dirty) begin
          cmd_o.lookup_rd = 1'b1;
          state_d         = ST_EMIT;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_PLOT_WR: begin
        cmd_o.plot_wr = 1'b1;
        state_d       = ST_IDLE;
      end
      ST_EMIT: begin
        // hold the fetched byte until the output register frees up
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

>>> design/lsdc_datapath.sv
`default_nettype none

module lsdc_datapath
  import lsdc_pkg::*;
#(
  parameter int CANVAS_SIZE = 128,
  parameter int COLOR_WIDTH = 32,
  parameter int DISPLAY_MAX = 512
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire cmd_t                   cmd_i,
  output status_t                     status_o,
  input  wire logic [2:0]             func_i,
  input  wire logic [9:0]             pos_x_i,
  input  wire logic [9:0]             pos_y_i,
  input  wire logic [12:0]            byte_addr_i,
  input  wire logic [31:0]            value_i,
  input  wire logic [3:0]             palette_index_i,
  input  wire logic                   palette_select_i,
  input  wire logic                   cfg_we_i,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data_i,
  output logic                        out_valid_o,
  input  wire logic                   out_ready_i,
  output logic      [31:0]            pixel_color_o,
  output logic      [9:0]             out_column_o,
  output logic      [8:0]             out_line_o
);

  localparam int RowBytes   = (CANVAS_SIZE + 1) / 2;
  localparam int StoreBytes = CANVAS_SIZE * RowBytes;
  localparam int AddrW      = $clog2(StoreBytes);
  localparam int CoordW     = $clog2(CANVAS_SIZE);
  localparam int LimW       = $clog2(DISPLAY_MAX + 1);
  localparam int CmpW       = (LimW > 9) ? LimW : 9;

  // Configuration registers
  logic [8:0]  disp_w_q, disp_h_q;
  logic [7:0]  x_offset_q;
  logic [17:0] x_ratio_q, y_ratio_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      disp_w_q   <= RESET_DISPLAY_WIDTH;
      disp_h_q   <= RESET_DISPLAY_HEIGHT;
      x_offset_q <= RESET_X_OFFSET;
      x_ratio_q  <= RESET_X_RATIO;
      y_ratio_q  <= RESET_Y_RATIO;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_DISPLAY_WIDTH:  disp_w_q   <= cfg_data_i[8:0];
        REG_DISPLAY_HEIGHT: disp_h_q   <= cfg_data_i[8:0];
        REG_X_OFFSET:       x_offset_q <= cfg_data_i[7:0];
        REG_X_RATIO:        x_ratio_q  <= cfg_data_i;
        REG_Y_RATIO:        y_ratio_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Item registers
  logic [2:0]  item_func_q;
  logic [9:0]  item_px_q, item_py_q;
  logic [12:0] item_addr_q;
  logic [31:0] item_value_q;
  logic [3:0]  item_pidx_q;
  logic        item_psel_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      item_func_q  <= func_i;
      item_px_q    <= pos_x_i;
      item_py_q    <= pos_y_i;
      item_addr_q  <= byte_addr_i;
      item_value_q <= value_i;
      item_pidx_q  <= palette_index_i;
      item_psel_q  <= palette_select_i;
    end
  end

  // Clearing sweep over both canvases
  logic [AddrW-1:0] clr_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (cmd_i.clr_en) begin
      clr_cnt_q <= clr_cnt_q + AddrW'(1);
    end
  end

  // Nearest-neighbour mapping, saturated at the canvas edge
  function automatic logic [CoordW-1:0] map_coord(logic [8:0] pos, logic [17:0] ratio);
    logic [26:0] prod;
    logic [10:0] c;
    prod = 27'(pos) * 27'(ratio);
    c    = prod[26:16];
    if (c > 11'(CANVAS_SIZE - 1)) begin
      return CoordW'(CANVAS_SIZE - 1);
    end
    return CoordW'(c);
  endfunction

  logic [CoordW-1:0] cx_q, cy_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.map_en) begin
      cx_q <= map_coord(item_px_q[8:0], x_ratio_q);
      cy_q <= map_coord(item_py_q[8:0], y_ratio_q);
    end
  end

  // Dirty lines
  logic [CANVAS_SIZE-1:0] dirty_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dirty_q <= '0;
    end else if (cmd_i.dirty_clear) begin
      dirty_q <= '0;
    end else if (cmd_i.dirty_set_all) begin
      dirty_q <= '1;
    end else if (cmd_i.plot_wr) begin
      dirty_q[item_py_q[CoordW-1:0]] <= 1'b1;
    end
  end

  // Palettes
  logic [COLOR_WIDTH-1:0] bg_pal_q  [PALETTE_DEPTH];
  logic [COLOR_WIDTH-1:0] spr_pal_q [PALETTE_DEPTH];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < PALETTE_DEPTH; i++) begin
        bg_pal_q[i]  <= '0;
        spr_pal_q[i] <= '0;
      end
    end else if (cmd_i.pal_wr) begin
      if (item_psel_q) begin
        spr_pal_q[item_pidx_q] <= item_value_q[COLOR_WIDTH-1:0];
      end else begin
        bg_pal_q[item_pidx_q] <= item_value_q[COLOR_WIDTH-1:0];
      end
    end
  end

  // Canvas addressing
  logic [AddrW-1:0] plot_addr, render_addr;

  assign plot_addr = AddrW'(item_py_q[CoordW-1:0]) * AddrW'(RowBytes)
                   + AddrW'(item_px_q[CoordW-1:0] >> 1);
  assign render_addr = AddrW'(cy_q) * AddrW'(RowBytes) + AddrW'(cx_q >> 1);

  logic [7:0] bg_rdata, spr_rdata, spr_wdata, plot_byte;

  // even x in the high nibble
  assign plot_byte = item_px_q[0] ? {spr_rdata[7:4], item_value_q[3:0]}
                                  : {item_value_q[3:0], spr_rdata[3:0]};
  assign spr_wdata = cmd_i.clr_en ? 8'h00 : plot_byte;

  lsdc_ram #(
    .Width (8),
    .Depth (StoreBytes)
  ) u_bg_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.clr_en | cmd_i.bg_wr),
    .waddr_i (cmd_i.clr_en ? clr_cnt_q : AddrW'(item_addr_q)),
    .wdata_i (cmd_i.clr_en ? 8'h00 : item_value_q[7:0]),
    .re_i    (cmd_i.lookup_rd),
    .raddr_i (render_addr),
    .rdata_o (bg_rdata)
  );

  lsdc_ram #(
    .Width (8),
    .Depth (StoreBytes)
  ) u_spr_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.clr_en | cmd_i.plot_wr),
    .waddr_i (cmd_i.clr_en ? clr_cnt_q : plot_addr),
    .wdata_i (spr_wdata),
    .re_i    (cmd_i.plot_rd | cmd_i.lookup_rd),
    .raddr_i (cmd_i.plot_rd ? plot_addr : render_addr),
    .rdata_o (spr_rdata)
  );

  // Layer select and palette lookup
  logic [3:0]             spr_nib, bg_nib;
  logic [COLOR_WIDTH-1:0] color;

  assign spr_nib = cx_q[0] ? spr_rdata[3:0] : spr_rdata[7:4];
  assign bg_nib  = cx_q[0] ? bg_rdata[3:0]  : bg_rdata[7:4];
  assign color   = (spr_nib != 4'd0) ? spr_pal_q[spr_nib] : bg_pal_q[bg_nib];

  // Output register
  logic        out_valid_q, out_valid_d;
  logic [31:0] pixel_q;
  logic [9:0]  column_q;
  logic [8:0]  line_q;

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      pixel_q  <= 32'(color);
      column_q <= item_px_q + {2'b00, x_offset_q};
      line_q   <= item_py_q[8:0];
    end
  end

  assign out_valid_o   = out_valid_q;
  assign pixel_color_o = pixel_q;
  assign out_column_o  = column_q;
  assign out_line_o    = line_q;

  // Range checks
  logic [CmpW-1:0] disp_max, w_lim, h_lim;

  assign disp_max = CmpW'(DISPLAY_MAX);
  assign w_lim = (CmpW'(disp_w_q) < disp_max) ? CmpW'(disp_w_q) : disp_max;
  assign h_lim = (CmpW'(disp_h_q) < disp_max) ? CmpW'(disp_h_q) : disp_max;

  assign status_o.func       = func_e'(item_func_q);
  assign status_o.clr_last   = (clr_cnt_q == AddrW'(StoreBytes - 1));
  assign status_o.bg_addr_ok = (32'(item_addr_q) < 32'(StoreBytes));
  assign status_o.plot_ok    = !item_px_q[9] && !item_py_q[9]
                            && (item_px_q[8:0] < 9'(CANVAS_SIZE))
                            && (item_py_q[8:0] < 9'(CANVAS_SIZE));
  assign status_o.render_ok  = !item_px_q[9] && !item_py_q[9]
                            && (CmpW'(item_px_q[8:0]) < w_lim)
                            && (CmpW'(item_py_q[8:0]) < h_lim);
  assign status_o.line_dirty = dirty_q[cy_q];
  assign status_o.out_free   = !out_valid_q || out_ready_i;

endmodule

`default_nettype wire

>>> design/layered_scaled_display_compositor.sv
// Render: the transfer in is captured, then decoded with the scale multiply, then the canvas RAMs
// are read and the palette lookup result is loaded into the output register; a render on a clean
// line ends before the RAM read, one outside the display after decode; a stalled result holds the
// render with input ready low. Sprite plot does a read-modify-write on the sprite RAM port.
// Reset is asynchronous, active low; afterwards both canvas RAMs, CANVAS_SIZE*((CANVAS_SIZE+1)/2)
// bytes each (8192 at the default), are swept to zero with input ready low.
`default_nettype none

module layered_scaled_display_compositor
  import lsdc_pkg::*;
#(
  parameter int CANVAS_SIZE = 128,
  parameter int COLOR_WIDTH = 32,
  parameter int DISPLAY_MAX = 512
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  output logic                        in_ready_o,
  input  wire logic [2:0]             func_i,
  input  wire logic [9:0]             pos_x_i,
  input  wire logic [9:0]             pos_y_i,
  input  wire logic [12:0]            byte_addr_i,
  input  wire logic [31:0]            value_i,
  input  wire logic [3:0]             palette_index_i,
  input  wire logic                   palette_select_i,
  output logic                        out_valid_o,
  input  wire logic                   out_ready_i,
  output logic      [31:0]            pixel_color_o,
  output logic      [9:0]             out_column_o,
  output logic      [8:0]             out_line_o,
  input  wire logic                   cfg_we_i,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data_i
);

  cmd_t    cmd;
  status_t status;

  lsdc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  lsdc_datapath #(
    .CANVAS_SIZE (CANVAS_SIZE),
    .COLOR_WIDTH (COLOR_WIDTH),
    .DISPLAY_MAX (DISPLAY_MAX)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .func_i           (func_i),
    .pos_x_i          (pos_x_i),
    .pos_y_i          (pos_y_i),
    .byte_addr_i      (byte_addr_i),
    .value_i          (value_i),
    .palette_index_i  (palette_index_i),
    .palette_select_i (palette_select_i),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .pixel_color_o    (pixel_color_o),
    .out_column_o     (out_column_o),
    .out_line_o       (out_line_o)
  );

endmodule

`default_nettype wire

>>> design/lsdc_checker.sv
`default_nettype none

module lsdc_checker
  import lsdc_pkg::*;
(
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_o,
  input wire logic [2:0]  func_i,
  input wire logic [9:0]  pos_y_i,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [31:0] pixel_color_o,
  input wire logic [9:0]  out_column_o,
  input wire logic [8:0]  out_line_o
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(pixel_color_o)
      && $stable(out_column_o) && $stable(out_line_o))
    else $error("result changed while stalled");

  // one item at a time: busy right after a transfer in
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input ready right after a transfer");

  // a fresh result comes from a render taken in earlier, through decode, lookup and emit
  a_result_from_render: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o && (func_i == FUNC_RENDER), 4))
    else $error("result without a render transfer");

  a_result_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> out_line_o == $past(pos_y_i[8:0], 4))
    else $error("result line does not match render position");

endmodule

bind layered_scaled_display_compositor lsdc_checker u_checker (.*);

`default_nettype wire
